@@ rtl/cltl_pkg.sv @@
// ----------------------------------------------------------------------------
// cltl_pkg
// Shared types, constants and command words for the two-level lru hit counter
// ----------------------------------------------------------------------------
package cltl_pkg;

   localparam int L1_DEPTH_DEF   = 64;
   localparam int L2_DEPTH_DEF   = 1024;
   localparam int WARP_LINES_DEF = 32;
   localparam int WARP_SIZE_DEF  = 32;

   // byte address is a 32 bit index times a 5 bit element size
   localparam int ADDR_W  = 37;
   localparam int KEY_W   = ADDR_W;
   localparam int WARP_W  = 16;
   localparam int CNT_W   = 32;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_L1_LINE_LOG2 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_L2_LINE_LOG2 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_L1_CAPACITY  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_L2_CAPACITY  = 2'd3;

   localparam logic [3:0] L1_LINE_LOG2_RST  = 4'd7;
   localparam logic [3:0] L2_LINE_LOG2_RST  = 4'd5;
   localparam logic [3:0] FALLBACK_LINE_LOG2 = 4'd5;

   typedef enum logic [2:0] {
      ST_NOP    = 3'd0,
      ST_FIND   = 3'd1,
      ST_TOUCH  = 3'd2,
      ST_INSERT = 3'd3,
      ST_APPEND = 3'd4,
      ST_CLEAR  = 3'd5,
      ST_SEED   = 3'd6
   } store_op_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } store_stat_type;

   typedef struct packed {
      logic [15:0] expr;
      logic        is_write;
      logic [7:0]  array;
   } group_type;

   typedef struct packed {
      logic [WARP_W-1:0] warp;
      logic [15:0]       loop;
      group_type         group;
   } keys_type;

   typedef struct packed {
      logic         load_item;
      logic         set_keys;
      logic         set_started;
      logic         clr_state;
      logic         seed_counts;
      logic         inc_total;
      logic         inc_l1;
      logic         inc_l2;
      logic         emit;
      logic         emit_last;
      store_op_type warp_op;
      store_op_type l1_op;
      store_op_type l2_op;
   } dp_cmd_type;

   typedef struct packed {
      logic           started;
      logic           group_change;
      logic           keys_change;
      logic           is_read;
      logic           final_item;
      logic           l1_on;
      logic           l2_on;
      logic           busy;
      logic           out_full;
      store_stat_type warp;
      store_stat_type l1;
      store_stat_type l2;
   } dp_stat_type;

endpackage

@@ rtl/cltl_store.sv @@
// ----------------------------------------------------------------------------
// cltl_store
// Ordered line store, oldest first, in a memory with one read and one write
// port. Lookup and reorder walk the filled entries one a cycle.
// ----------------------------------------------------------------------------
module cltl_store #(
   parameter int DEPTH = 64,
   parameter int KW    = 37,
   localparam int FW   = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cltl_pkg::store_op_type op,
   input  logic [KW-1:0]         key,
   input  logic [FW-1:0]         cap,
   output cltl_pkg::store_stat_type stat
);
   import cltl_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      SM_IDLE  = 3'b001,
      SM_FIND  = 3'b010,
      SM_SHIFT = 3'b100
   } mode_type;

   logic [KW-1:0] mem [DEPTH];

   mode_type      mode_ff, mode_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] ptr_ff, ptr_in;
   logic [KW-1:0] key_ff, key_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [AW-1:0] rd_idx_ff;
   logic [KW-1:0] rd_data_ff;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [KW-1:0] wr_data;
   logic [FW-1:0] fill_m1;

   assign fill_m1 = fill_ff - FW'(1);

   always_comb begin
      mode_in     = mode_ff;
      fill_in     = fill_ff;
      ptr_in      = ptr_ff;
      key_in      = key_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      rd_valid_in = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = ptr_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = fill_ff[AW-1:0];
      wr_data     = key;
      unique case (mode_ff)
         SM_IDLE: begin
            unique case (op)
               ST_FIND: begin
                  hit_in  = 1'b0;
                  ptr_in  = '0;
                  key_in  = key;
                  mode_in = SM_FIND;
               end
               ST_TOUCH: begin
                  ptr_in  = FW'(hit_idx_ff) + FW'(1);
                  key_in  = key;
                  mode_in = SM_SHIFT;
               end
               ST_INSERT: begin
                  if (cap != '0) begin
                     if (fill_ff >= cap && fill_ff != '0) begin
                        // drop the oldest: same walk as a touch of entry zero
                        ptr_in  = FW'(1);
                        key_in  = key;
                        mode_in = SM_SHIFT;
                     end else if (fill_ff < FW'(DEPTH)) begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + FW'(1);
                     end
                  end
               end
               ST_APPEND: begin
                  if (fill_ff < FW'(DEPTH)) begin
                     wr_en   = 1'b1;
                     fill_in = fill_ff + FW'(1);
                  end
               end
               ST_CLEAR: begin
                  fill_in = '0;
               end
               ST_SEED: begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  fill_in = FW'(1);
               end
               default: begin
               end
            endcase
         end
         SM_FIND: begin
            if (rd_valid_ff && rd_data_ff == key_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = rd_idx_ff;
               mode_in    = SM_IDLE;
            end else if (ptr_ff < fill_ff) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               ptr_in      = ptr_ff + FW'(1);
            end else if (!rd_valid_ff) begin
               mode_in = SM_IDLE;
            end
         end
         SM_SHIFT: begin
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - AW'(1);
               wr_data = rd_data_ff;
            end
            if (ptr_ff < fill_ff) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               ptr_in      = ptr_ff + FW'(1);
            end else if (!rd_valid_ff) begin
               // newest slot takes the touched or inserted line
               wr_en   = 1'b1;
               wr_addr = fill_m1[AW-1:0];
               wr_data = key_ff;
               mode_in = SM_IDLE;
            end
         end
         default: begin
            mode_in = SM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= SM_IDLE;
         fill_ff     <= '0;
         hit_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         fill_ff     <= fill_in;
         hit_ff      <= hit_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      key_ff     <= key_in;
      hit_idx_ff <= hit_idx_in;
      rd_idx_ff  <= ptr_ff[AW-1:0];
   end

   assign stat.busy = (mode_ff != SM_IDLE);
   assign stat.hit  = hit_ff;

endmodule

@@ rtl/cltl_datapath.sv @@
// ----------------------------------------------------------------------------
// cltl_datapath
// Item registers, line key arithmetic, the three line stores, group counters
// and the report register
// ----------------------------------------------------------------------------
module cltl_datapath #(
   parameter int L1_DEPTH   = 64,
   parameter int L2_DEPTH   = 1024,
   parameter int WARP_LINES = 32,
   parameter int WARP_SIZE  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [cltl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cltl_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic [7:0]                         req_array_id,
   input  logic                               req_is_write,
   input  logic [15:0]                        req_expr_id,
   input  logic [15:0]                        req_loop_id,
   input  logic [15:0]                        req_thread_id,
   input  logic [31:0]                        req_element_index,
   input  logic [4:0]                         req_element_bytes,
   input  logic                               req_final_item,
   input  cltl_pkg::dp_cmd_type               cmd,
   output cltl_pkg::dp_stat_type              stat,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_report_array,
   output logic [15:0]                        rsp_report_expr,
   output logic [31:0]                        rsp_l1_hits,
   output logic [31:0]                        rsp_l2_hits,
   output logic [31:0]                        rsp_global_accesses,
   output logic                               rsp_last_report
);
   import cltl_pkg::*;

   localparam int L1_FW   = $clog2(L1_DEPTH + 1);
   localparam int L2_FW   = $clog2(L2_DEPTH + 1);
   localparam int WL_FW   = $clog2(WARP_LINES + 1);
   // thread / WARP_SIZE as a multiply by a rounded-up reciprocal, exact for 16 bits
   localparam int WS_LOG  = (WARP_SIZE > 1) ? $clog2(WARP_SIZE) : 0;
   localparam int RSHIFT  = 16 + WS_LOG;
   localparam int RECIP_W = RSHIFT + 1;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << RSHIFT) + 64'(WARP_SIZE) - 64'd1) / 64'(WARP_SIZE);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   // configuration
   logic [3:0]  l1_log_ff, l2_log_ff;
   logic [6:0]  l1_cap_ff;
   logic [10:0] l2_cap_ff;

   // item
   logic [7:0]  array_ff;
   logic        wr_ff;
   logic [15:0] expr_ff, loop_ff, thread_ff;
   logic [31:0] index_ff;
   logic [4:0]  bytes_ff;
   logic        final_ff;

   logic [ADDR_W-1:0]      addr_ff;
   logic [WARP_W-1:0]      warp_ff;
   logic [16+RECIP_W-1:0]  warp_prod;
   logic [KEY_W-1:0]       k1_ff, k2_ff;
   logic [3:0]             clog, l2log;
   logic [L1_FW-1:0]       cap1;
   logic [L2_FW-1:0]       cap2;

   keys_type   item_keys;
   keys_type   cur_keys_ff;
   logic       started_ff;

   logic [CNT_W-1:0] l1_cnt_ff, l2_cnt_ff, total_ff;

   store_stat_type warp_stat, l1_stat, l2_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_log_ff <= L1_LINE_LOG2_RST;
         l2_log_ff <= L2_LINE_LOG2_RST;
         l1_cap_ff <= '0;
         l2_cap_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_L1_LINE_LOG2: l1_log_ff <= csr_data[3:0];
            CSR_L2_LINE_LOG2: l2_log_ff <= csr_data[3:0];
            CSR_L1_CAPACITY:  l1_cap_ff <= csr_data[6:0];
            CSR_L2_CAPACITY:  l2_cap_ff <= csr_data[10:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (l1_cap_ff != '0) begin
         clog = l1_log_ff;
      end else if (l2_cap_ff != '0) begin
         clog = l2_log_ff;
      end else begin
         clog = FALLBACK_LINE_LOG2;
      end
      l2log = (l2_log_ff < clog) ? clog : l2_log_ff;
      cap1 = (int'(l1_cap_ff) > L1_DEPTH) ? L1_FW'(L1_DEPTH) : L1_FW'(l1_cap_ff);
      cap2 = (int'(l2_cap_ff) > L2_DEPTH) ? L2_FW'(L2_DEPTH) : L2_FW'(l2_cap_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         array_ff  <= req_array_id;
         wr_ff     <= req_is_write;
         expr_ff   <= req_expr_id;
         loop_ff   <= req_loop_id;
         thread_ff <= req_thread_id;
         index_ff  <= req_element_index;
         bytes_ff  <= req_element_bytes;
         final_ff  <= req_final_item;
      end
   end

   assign warp_prod = (16+RECIP_W)'(thread_ff) * (16+RECIP_W)'(RECIP);

   // product, then shifted keys, one register stage each
   always_ff @(posedge clock) begin
      addr_ff <= ADDR_W'(index_ff) * ADDR_W'(bytes_ff);
      warp_ff <= WARP_W'(warp_prod >> RSHIFT);
      k1_ff   <= addr_ff >> clog;
      k2_ff   <= addr_ff >> l2log;
   end

   assign item_keys.warp           = warp_ff;
   assign item_keys.loop           = loop_ff;
   assign item_keys.group.expr     = expr_ff;
   assign item_keys.group.is_write = wr_ff;
   assign item_keys.group.array    = array_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_keys_ff <= '0;
         started_ff  <= 1'b0;
      end else begin
         if (cmd.clr_state) begin
            cur_keys_ff <= '0;
            started_ff  <= 1'b0;
         end else begin
            if (cmd.set_keys) begin
               cur_keys_ff <= item_keys;
            end
            if (cmd.set_started) begin
               started_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_cnt_ff <= '0;
         l2_cnt_ff <= '0;
         total_ff  <= '0;
      end else if (cmd.clr_state) begin
         l1_cnt_ff <= '0;
         l2_cnt_ff <= '0;
         total_ff  <= '0;
      end else if (cmd.seed_counts) begin
         l1_cnt_ff <= '0;
         l2_cnt_ff <= '0;
         total_ff  <= CNT_W'(1);
      end else begin
         if (cmd.inc_total) total_ff  <= total_ff + CNT_W'(1);
         if (cmd.inc_l1)    l1_cnt_ff <= l1_cnt_ff + CNT_W'(1);
         if (cmd.inc_l2)    l2_cnt_ff <= l2_cnt_ff + CNT_W'(1);
      end
   end

   cltl_store #(.DEPTH(WARP_LINES), .KW(KEY_W)) u_warp (
      .clock (clock),
      .reset (reset),
      .op    (cmd.warp_op),
      .key   (k1_ff),
      .cap   (WL_FW'(WARP_LINES)),
      .stat  (warp_stat)
   );

   cltl_store #(.DEPTH(L1_DEPTH), .KW(KEY_W)) u_l1 (
      .clock (clock),
      .reset (reset),
      .op    (cmd.l1_op),
      .key   (k1_ff),
      .cap   (cap1),
      .stat  (l1_stat)
   );

   cltl_store #(.DEPTH(L2_DEPTH), .KW(KEY_W)) u_l2 (
      .clock (clock),
      .reset (reset),
      .op    (cmd.l2_op),
      .key   (k2_ff),
      .cap   (cap2),
      .stat  (l2_stat)
   );

   // report word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_report_array    <= cur_keys_ff.group.array;
         rsp_report_expr     <= cur_keys_ff.group.expr;
         rsp_l1_hits         <= l1_cnt_ff;
         rsp_l2_hits         <= l2_cnt_ff;
         rsp_global_accesses <= total_ff - l1_cnt_ff - l2_cnt_ff;
         rsp_last_report     <= cmd.emit_last;
      end
   end

   assign stat.started      = started_ff;
   assign stat.group_change = (cur_keys_ff.group != item_keys.group);
   assign stat.keys_change  = (cur_keys_ff != item_keys);
   assign stat.is_read      = !wr_ff;
   assign stat.final_item   = final_ff;
   assign stat.l1_on        = (cap1 != '0);
   assign stat.l2_on        = (cap2 != '0);
   assign stat.busy         = warp_stat.busy | l1_stat.busy | l2_stat.busy;
   assign stat.out_full     = rsp_valid;
   assign stat.warp         = warp_stat;
   assign stat.l1           = l1_stat;
   assign stat.l2           = l2_stat;

endmodule

@@ rtl/cltl_ctrl.sv @@
// ----------------------------------------------------------------------------
// cltl_ctrl
// Sequencer: takes one word, walks it through lookup, update and reporting
// ----------------------------------------------------------------------------
module cltl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output cltl_pkg::dp_cmd_type  cmd,
   input  cltl_pkg::dp_stat_type stat
);
   import cltl_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_MUL      = 11'b000_0000_0010,
      S_KEY      = 11'b000_0000_0100,
      S_DECIDE   = 11'b000_0000_1000,
      S_FIND     = 11'b000_0001_0000,
      S_WAIT1    = 11'b000_0010_0000,
      S_WAIT2    = 11'b000_0100_0000,
      S_EMIT_OLD = 11'b000_1000_0000,
      S_SEED     = 11'b001_0000_0000,
      S_FIN      = 11'b010_0000_0000,
      S_EMIT_FIN = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_MUL;
            end
         end
         S_MUL: state_in = S_KEY;
         S_KEY: state_in = S_DECIDE;
         S_DECIDE: begin
            if (!stat.started) begin
               cmd.set_started = 1'b1;
               cmd.set_keys    = 1'b1;
               state_in        = S_FIND;
            end else if (stat.group_change) begin
               state_in = S_EMIT_OLD;
            end else begin
               if (stat.keys_change) begin
                  cmd.warp_op  = ST_CLEAR;
                  cmd.set_keys = 1'b1;
               end
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            cmd.warp_op = ST_FIND;
            cmd.l1_op   = ST_FIND;
            cmd.l2_op   = ST_FIND;
            state_in    = S_WAIT1;
         end
         S_WAIT1: begin
            if (!stat.busy) begin
               if (stat.warp.hit) begin
                  state_in = S_FIN;
               end else begin
                  cmd.inc_total = 1'b1;
                  if (stat.l1.hit) begin
                     if (stat.is_read) begin
                        cmd.inc_l1 = 1'b1;
                        cmd.l1_op  = ST_TOUCH;
                     end
                  end else begin
                     if (stat.is_read) begin
                        cmd.l1_op = ST_INSERT;
                     end
                     if (stat.l2.hit) begin
                        cmd.inc_l2 = 1'b1;
                        cmd.l2_op  = ST_TOUCH;
                     end else begin
                        cmd.l2_op = ST_INSERT;
                     end
                  end
                  cmd.warp_op = ST_APPEND;
                  state_in    = S_WAIT2;
               end
            end
         end
         S_WAIT2: begin
            if (!stat.busy) begin
               state_in = S_FIN;
            end
         end
         S_EMIT_OLD: begin
            if (!stat.out_full) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = !stat.final_item;
               state_in      = S_SEED;
            end
         end
         S_SEED: begin
            // new group opens with its first line already in place
            cmd.seed_counts = 1'b1;
            cmd.set_keys    = 1'b1;
            cmd.warp_op     = ST_SEED;
            cmd.l1_op       = stat.l1_on ? ST_SEED : ST_CLEAR;
            cmd.l2_op       = stat.l2_on ? ST_SEED : ST_CLEAR;
            state_in        = S_FIN;
         end
         S_FIN: begin
            state_in = stat.final_item ? S_EMIT_FIN : S_IDLE;
         end
         S_EMIT_FIN: begin
            if (!stat.out_full) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               cmd.clr_state = 1'b1;
               cmd.warp_op   = ST_CLEAR;
               cmd.l1_op     = ST_CLEAR;
               cmd.l2_op     = ST_CLEAR;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

@@ rtl/coalesced_two_level_lru_hit_counter.sv @@
// ----------------------------------------------------------------------------
// coalesced_two_level_lru_hit_counter
// Counts L1 and L2 lru hits of coalesced warp accesses per access group
// ----------------------------------------------------------------------------
//  channel   dir   handshake              carries
//  req_      in    req_valid / req_ready  one access record
//  rsp_      out   rsp_valid / rsp_ready  one group report
//  csr_      in    csr_wr_en              register index and data, no wait
//
//  one record at a time: up to two walks over the L2 store (lookup, then
//  reorder), one entry a cycle; with a full 1024 line L2 its memory port
//  sets the pace
//  reset is synchronous; stores are emptied by their fill counts, no sweep
//  a pending report waits in its register while the next record is taken;
//  only a second report stalls the sequencer until the first is taken
// ----------------------------------------------------------------------------
module coalesced_two_level_lru_hit_counter #(
   parameter int L1_DEPTH   = cltl_pkg::L1_DEPTH_DEF,
   parameter int L2_DEPTH   = cltl_pkg::L2_DEPTH_DEF,
   parameter int WARP_LINES = cltl_pkg::WARP_LINES_DEF,
   parameter int WARP_SIZE  = cltl_pkg::WARP_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [cltl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cltl_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_array_id,
   input  logic                            req_is_write,
   input  logic [15:0]                     req_expr_id,
   input  logic [15:0]                     req_loop_id,
   input  logic [15:0]                     req_thread_id,
   input  logic [31:0]                     req_element_index,
   input  logic [4:0]                      req_element_bytes,
   input  logic                            req_final_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_report_array,
   output logic [15:0]                     rsp_report_expr,
   output logic [31:0]                     rsp_l1_hits,
   output logic [31:0]                     rsp_l2_hits,
   output logic [31:0]                     rsp_global_accesses,
   output logic                            rsp_last_report
);
   import cltl_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   cltl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   cltl_datapath #(
      .L1_DEPTH   (L1_DEPTH),
      .L2_DEPTH   (L2_DEPTH),
      .WARP_LINES (WARP_LINES),
      .WARP_SIZE  (WARP_SIZE)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_array_id        (req_array_id),
      .req_is_write        (req_is_write),
      .req_expr_id         (req_expr_id),
      .req_loop_id         (req_loop_id),
      .req_thread_id       (req_thread_id),
      .req_element_index   (req_element_index),
      .req_element_bytes   (req_element_bytes),
      .req_final_item      (req_final_item),
      .cmd                 (dp_cmd),
      .stat                (dp_stat),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_report_array    (rsp_report_array),
      .rsp_report_expr     (rsp_report_expr),
      .rsp_l1_hits         (rsp_l1_hits),
      .rsp_l2_hits         (rsp_l2_hits),
      .rsp_global_accesses (rsp_global_accesses),
      .rsp_last_report     (rsp_last_report)
   );

   // a report never overwrites one still waiting
   a_no_report_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |-> !dp_stat.out_full)
      else $error("report issued while previous report pending");

   // one record in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("record taken while another is in flight");

   // an l1 hit is only counted for a read that also counts as a line
   a_l1_hit_read: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.inc_l1 |-> dp_cmd.inc_total && dp_stat.is_read && !dp_cmd.inc_l2)
      else $error("l1 hit counted outside a read line");

   // store updates start only once all lookups are finished
   a_update_after_lookup: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.inc_total |-> !dp_stat.busy && !dp_stat.warp.hit)
      else $error("line counted during lookup or on warp hit");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the coalesced two-level lru hit counter: drives
// access records, predicts each group report and compares every field
// ----------------------------------------------------------------------------
module tb;
   import cltl_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 2300;

   typedef struct {
      bit [7:0]  array_id;
      bit        is_write;
      bit [15:0] expr_id;
      bit [15:0] loop_id;
      bit [15:0] thread_id;
      bit [31:0] element_index;
      bit [4:0]  element_bytes;
      bit        final_item;
   } access_type;

   typedef struct {
      bit [7:0]  report_array;
      bit [15:0] report_expr;
      bit [31:0] l1_hits;
      bit [31:0] l2_hits;
      bit [31:0] global_accesses;
      bit        last_report;
   } report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_array_id = '0;
   logic req_is_write = 1'b0;
   logic [15:0] req_expr_id = '0;
   logic [15:0] req_loop_id = '0;
   logic [15:0] req_thread_id = '0;
   logic [31:0] req_element_index = '0;
   logic [4:0] req_element_bytes = '0;
   logic req_final_item = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_report_array;
   logic [15:0] rsp_report_expr;
   logic [31:0] rsp_l1_hits;
   logic [31:0] rsp_l2_hits;
   logic [31:0] rsp_global_accesses;
   logic rsp_last_report;

   coalesced_two_level_lru_hit_counter u_dut (.*);

   always #6 clock = ~clock;

   // predictor state
   bit [3:0]  l1_log2_reg, l2_log2_reg;
   bit [6:0]  l1_cap_reg;
   bit [10:0] l2_cap_reg;
   bit [36:0] l1_tags[], l2_tags[], warp_lines[];
   int        l1_fill, l2_fill, warp_fill;
   bit [31:0] l1_hit_cnt, l2_hit_cnt, line_total;
   bit [7:0]  cur_array;
   bit        cur_write;
   bit [15:0] cur_expr, cur_loop;
   bit [10:0] cur_warp;
   bit        group_open;

   report_type pending_reports[$];
   int        error_count = 0;
   int        idle_pct = 0;
   int        stall_pct = 0;
   int        quiet_cycles = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void clear_counts();
      l1_fill = 0;
      l2_fill = 0;
      warp_fill = 0;
      l1_hit_cnt = 0;
      l2_hit_cnt = 0;
      line_total = 0;
      cur_array = 0;
      cur_write = 0;
      cur_expr = 0;
      cur_loop = 0;
      cur_warp = 0;
      group_open = 0;
   endfunction

   function automatic int find_line(ref bit [36:0] s[], input int n, input bit [36:0] k);
      for (int i = 0; i < n; i++) if (s[i] == k) return i;
      return -1;
   endfunction

   function automatic void promote_line(ref bit [36:0] s[], input int n, input int idx);
      bit [36:0] k;
      k = s[idx];
      for (int i = idx; i < n - 1; i++) s[i] = s[i + 1];
      s[n - 1] = k;
   endfunction

   function automatic void insert_line(ref bit [36:0] s[], ref int fill, input int cap,
                                       input int depth, input bit [36:0] k);
      if (cap == 0) return;
      if (fill >= cap && fill > 0) begin
         for (int i = 0; i < fill - 1; i++) s[i] = s[i + 1];
         fill--;
      end
      if (fill < depth) begin
         s[fill] = k;
         fill++;
      end
   endfunction

   function automatic void touch_lines(bit [36:0] k1, bit [36:0] k2, bit rd, int cap1, int cap2);
      int i1, i2;
      if (find_line(warp_lines, warp_fill, k1) >= 0) return;
      line_total++;
      i1 = find_line(l1_tags, l1_fill, k1);
      if (i1 >= 0) begin
         if (rd) begin
            l1_hit_cnt++;
            promote_line(l1_tags, l1_fill, i1);
         end
      end else begin
         if (rd) insert_line(l1_tags, l1_fill, cap1, L1_DEPTH_DEF, k1);
         i2 = find_line(l2_tags, l2_fill, k2);
         if (i2 >= 0) begin
            l2_hit_cnt++;
            promote_line(l2_tags, l2_fill, i2);
         end else begin
            insert_line(l2_tags, l2_fill, cap2, L2_DEPTH_DEF, k2);
         end
      end
      if (warp_fill < WARP_LINES_DEF) begin
         warp_lines[warp_fill] = k1;
         warp_fill++;
      end
   endfunction

   function automatic void push_report(bit last);
      report_type r;
      r.report_array = cur_array;
      r.report_expr = cur_expr;
      r.l1_hits = l1_hit_cnt;
      r.l2_hits = l2_hit_cnt;
      r.global_accesses = line_total - l1_hit_cnt - l2_hit_cnt;
      r.last_report = last;
      pending_reports.insert(pending_reports.size(), r);
   endfunction

   function automatic void predict_reports(access_type a);
      int cap1, cap2;
      bit [3:0] clog, l2log;
      bit [36:0] addr, k1, k2;
      bit [10:0] warp;
      cap1 = (l1_cap_reg > L1_DEPTH_DEF) ? L1_DEPTH_DEF : l1_cap_reg;
      cap2 = (l2_cap_reg > L2_DEPTH_DEF) ? L2_DEPTH_DEF : l2_cap_reg;
      if (l1_cap_reg != 0) clog = l1_log2_reg;
      else if (l2_cap_reg != 0) clog = l2_log2_reg;
      else clog = FALLBACK_LINE_LOG2;
      l2log = (l2_log2_reg < clog) ? clog : l2_log2_reg;
      addr = 37'(a.element_index) * 37'(a.element_bytes);
      k1 = addr >> clog;
      k2 = addr >> l2log;
      warp = a.thread_id[15:5];
      if (!group_open) begin
         clear_counts();
         group_open = 1;
         {cur_array, cur_write, cur_expr} = {a.array_id, a.is_write, a.expr_id};
         {cur_loop, cur_warp} = {a.loop_id, warp};
         touch_lines(k1, k2, !a.is_write, cap1, cap2);
      end else if ({cur_array, cur_write, cur_expr} != {a.array_id, a.is_write, a.expr_id}) begin
         push_report(!a.final_item);
         clear_counts();
         group_open = 1;
         {cur_array, cur_write, cur_expr} = {a.array_id, a.is_write, a.expr_id};
         {cur_loop, cur_warp} = {a.loop_id, warp};
         // new group is seeded, never counted as a hit
         warp_lines[0] = k1;
         warp_fill = 1;
         line_total = 1;
         if (cap1 > 0) begin
            l1_tags[0] = k1;
            l1_fill = 1;
         end
         if (cap2 > 0) begin
            l2_tags[0] = k2;
            l2_fill = 1;
         end
      end else begin
         if ({cur_loop, cur_warp} != {a.loop_id, warp}) begin
            warp_fill = 0;
            {cur_loop, cur_warp} = {a.loop_id, warp};
         end
         touch_lines(k1, k2, !a.is_write, cap1, cap2);
      end
      if (a.final_item) begin
         push_report(1'b1);
         clear_counts();
      end
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      report_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               report_mismatch("unexpected report array", rsp_report_array, 0);
            end else begin
               want = pending_reports.pop_front();
               if (rsp_report_array !== want.report_array)
                  report_mismatch("report_array", rsp_report_array, want.report_array);
               if (rsp_report_expr !== want.report_expr)
                  report_mismatch("report_expr", rsp_report_expr, want.report_expr);
               if (rsp_l1_hits !== want.l1_hits)
                  report_mismatch("l1_hits", rsp_l1_hits, want.l1_hits);
               if (rsp_l2_hits !== want.l2_hits)
                  report_mismatch("l2_hits", rsp_l2_hits, want.l2_hits);
               if (rsp_global_accesses !== want.global_accesses)
                  report_mismatch("global_accesses", rsp_global_accesses, want.global_accesses);
               if (rsp_last_report !== want.last_report)
                  report_mismatch("last_report", rsp_last_report, want.last_report);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_pct == 0) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // returns right after the edge at which the word was taken
   task automatic send_access(input access_type a);
      int gap;
      gap = 0;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_array_id <= a.array_id;
      req_is_write <= a.is_write;
      req_expr_id <= a.expr_id;
      req_loop_id <= a.loop_id;
      req_thread_id <= a.thread_id;
      req_element_index <= a.element_index;
      req_element_bytes <= a.element_bytes;
      req_final_item <= a.final_item;
      do @(posedge clock); while (!req_ready);
      predict_reports(a);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      // a record that reports nothing may still be walking the stores
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(input bit [3:0] l1_log2, input bit [3:0] l2_log2,
                           input bit [6:0] l1_cap, input bit [10:0] l2_cap);
      bit [CSR_IDX_W-1:0]  idx[4];
      bit [CSR_DATA_W-1:0] val[4];
      idx = '{CSR_L1_LINE_LOG2, CSR_L2_LINE_LOG2, CSR_L1_CAPACITY, CSR_L2_CAPACITY};
      val = '{11'(l1_log2), 11'(l2_log2), 11'(l1_cap), l2_cap};
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      l1_log2_reg = l1_log2;
      l2_log2_reg = l2_log2;
      l1_cap_reg = l1_cap;
      l2_cap_reg = l2_cap;
   endtask

   function automatic access_type make_access(bit [7:0] arr, bit wr, bit [15:0] ex,
                                              bit [15:0] lp, bit [15:0] th, bit [31:0] idx,
                                              bit [4:0] nb, bit fin);
      access_type a;
      a = '{arr, wr, ex, lp, th, idx, nb, fin};
      return a;
   endfunction

   task automatic test_defaults();
      // reset register values: no cache, 32 byte fallback line
      send_access(make_access(8'd1, 1'b0, 16'd3, 16'd0, 16'd0, 32'd0, 5'd4, 1'b0));
      send_access(make_access(8'd1, 1'b0, 16'd3, 16'd0, 16'd1, 32'd9, 5'd4, 1'b0));
      send_access(make_access(8'd1, 1'b0, 16'd3, 16'd0, 16'd40, 32'd1, 5'd4, 1'b1));
   endtask

   task automatic test_field_extremes();
      set_regs(4'd7, 4'd5, 7'd64, 11'd1024);
      send_access(make_access(8'hff, 1'b1, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff,
                              5'd31, 1'b0));
      send_access(make_access(8'hff, 1'b1, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff,
                              5'd0, 1'b0));
      send_access(make_access(8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 32'h0, 5'd1, 1'b0));
      send_access(make_access(8'h00, 1'b0, 16'h0000, 16'h0001, 16'h0000, 32'h0, 5'd16, 1'b0));
      send_access(make_access(8'h00, 1'b1, 16'h0000, 16'h0001, 16'h0000, 32'h0, 5'd16, 1'b0));
      send_access(make_access(8'h00, 1'b1, 16'h0000, 16'h0002, 16'h0000, 32'h0, 5'd16, 1'b1));
   endtask

   task automatic test_hits_and_group_change();
      set_regs(4'd4, 4'd6, 7'd4, 11'd8);
      // read fills L1, another loop reads again: L1 hit; write hitting L1: no hit
      send_access(make_access(8'd5, 1'b0, 16'd7, 16'd0, 16'd0, 32'd0, 5'd4, 1'b0));
      send_access(make_access(8'd5, 1'b0, 16'd7, 16'd1, 16'd0, 32'd0, 5'd4, 1'b0));
      send_access(make_access(8'd5, 1'b0, 16'd7, 16'd2, 16'd0, 32'd8, 5'd4, 1'b0));
      send_access(make_access(8'd5, 1'b1, 16'd8, 16'd0, 16'd0, 32'd0, 5'd4, 1'b0));
      send_access(make_access(8'd5, 1'b1, 16'd8, 16'd1, 16'd0, 32'd0, 5'd4, 1'b0));
      send_access(make_access(8'd5, 1'b1, 16'd8, 16'd2, 16'd0, 32'd64, 5'd4, 1'b0));
      // group change together with the last record: two reports
      send_access(make_access(8'd6, 1'b0, 16'd8, 16'd0, 16'd0, 32'd0, 5'd4, 1'b1));
   endtask

   task automatic test_warp_list_full();
      set_regs(4'd0, 4'd0, 7'd2, 11'd3);
      for (int i = 0; i < 34; i++)
         send_access(make_access(8'd9, 1'b0, 16'd1, 16'd0, 16'(i), 32'(i), 5'd1, 1'b0));
      // a warp change clears the list: earlier lines count again
      send_access(make_access(8'd9, 1'b0, 16'd1, 16'd0, 16'd31, 32'd33, 5'd1, 1'b0));
      send_access(make_access(8'd9, 1'b0, 16'd1, 16'd0, 16'd31, 32'd32, 5'd1, 1'b1));
   endtask

   task automatic test_random_streams(input int n_items);
      bit [3:0]  l1s[8] = '{7, 0, 12, 15, 4, 6, 0, 5};
      bit [3:0]  l2s[8] = '{5, 0, 12, 15, 6, 3, 8, 5};
      bit [6:0]  c1s[8] = '{0, 1, 64, 127, 8, 2, 0, 64};
      bit [10:0] c2s[8] = '{0, 1, 1024, 2047, 16, 0, 40, 3};
      int idles[4] = '{0, 73, 0, 32};
      int stalls[4] = '{0, 0, 73, 32};
      int per_phase, sent, glen;
      access_type a;
      bit [31:0] base;
      per_phase = n_items / 8;
      for (int p = 0; p < 8; p++) begin
         set_regs(l1s[p], l2s[p], c1s[p], c2s[p]);
         idle_pct = idles[p % 4];
         stall_pct = stalls[p % 4];
         sent = 0;
         while (sent < per_phase) begin
            glen = $urandom_range(1, 24);
            a.array_id = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
            a.is_write = 1'($urandom_range(0, 1));
            a.expr_id = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
            a.loop_id = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 7));
            a.element_bytes = $urandom_range(0, 9) == 0 ? 5'($urandom) : 5'($urandom_range(1, 16));
            base = $urandom;
            for (int j = 0; j < glen; j++) begin
               if ($urandom_range(0, 3) == 0) a.loop_id++;
               if ($urandom_range(0, 9) == 0) a.thread_id = 16'($urandom);
               else a.thread_id = 16'($urandom_range(0, 95));
               if ($urandom_range(0, 9) == 0) a.element_index = $urandom;
               else a.element_index = base + $urandom_range(0, 80);
               a.final_item = (j == glen - 1) && ($urandom_range(0, 4) == 0);
               // occasional noise word breaking the group
               if ($urandom_range(0, 19) == 0) begin
                  access_type z;
                  z = make_access(8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), $urandom, 5'($urandom),
                                  $urandom_range(0, 9) == 0);
                  send_access(z);
               end else begin
                  send_access(a);
               end
               sent++;
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            idle_pct = 0;
            stall_pct = 0;
         end
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      l1_tags = new[L1_DEPTH_DEF];
      l2_tags = new[L2_DEPTH_DEF];
      warp_lines = new[WARP_LINES_DEF];
      l1_log2_reg = L1_LINE_LOG2_RST;
      l2_log2_reg = L2_LINE_LOG2_RST;
      l1_cap_reg = 0;
      l2_cap_reg = 0;
      clear_counts();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_field_extremes();
      test_hits_and_group_change();
      test_warp_list_full();
      test_random_streams(1000);
      wait_idle();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
